>>> hw/rtl/bdq_pkg.sv
// Shared types and codes for the bounded deque with search and delete.
package bdq_pkg;

    // Operation codes carried in the request
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;
    localparam logic [2:0] OP_DELETE     = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] key_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic               found;
        logic [1:0]         status;
        logic [4:0]         entry_count;
    } res_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic exec;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic needs_scan;
        logic scan_last;
        logic res_free;
    } dp_status_t;

endpackage

>>> hw/rtl/bdq_ctrl.sv
// Sequencing state machine for the deque: accept, match scan, execute.
module bdq_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  bdq_pkg::dp_status_t    sts,
    output bdq_pkg::ctrl_t         ctl
);
    import bdq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = sts.needs_scan ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctl       = '0;
        cmd_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                cmd_stall  = 1'b0;
                ctl.accept = cmd_valid;
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
            end
            S_EXEC:
            begin
                ctl.exec = sts.res_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> hw/rtl/bdq_datapath.sv
// Row of entry cells, match vector, occupancy and result register.
module bdq_datapath
#(
    parameter int CAPACITY = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bdq_pkg::req_t          cmd,
    input  bdq_pkg::ctrl_t         ctl,
    output bdq_pkg::dp_status_t    sts,
    output bdq_pkg::res_t          res,
    output logic                   res_valid,
    input  logic                   res_stall
);
    import bdq_pkg::*;

    localparam int OW    = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int NSTEP = IW;
    localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    logic [31:0]         cells_reg [CAPACITY];
    logic [31:0]         cells_next [CAPACITY];
    logic [31:0]         cells_exec [CAPACITY];
    logic [CAPACITY-1:0] hit_reg;
    logic [CAPACITY-1:0] hit_next;
    logic [OW-1:0]       occ_reg;
    logic [OW-1:0]       occ_next;
    logic [OW-1:0]       occ_exec;
    logic [SW-1:0]       step_reg;
    logic [SW-1:0]       step_next;
    logic [2:0]          op_reg;
    logic [2:0]          op_next;
    logic [31:0]         key_reg;
    logic [31:0]         key_next;
    res_t                res_reg;
    res_t                res_next;
    res_t                res_exec;
    logic                res_valid_reg;
    logic                res_valid_next;
    logic [NSTEP-1:0]    shamt;
    logic [IW-1:0]       last_idx;
    logic                full;
    logic                empty;

    assign full     = (occ_reg == OW'(CAPACITY));
    assign empty    = (occ_reg == '0);
    assign last_idx = IW'(occ_reg - OW'(1));
    assign shamt    = NSTEP'(1) << step_reg;

    assign sts.needs_scan = (cmd.operation == OP_SEARCH) || (cmd.operation == OP_DELETE);
    assign sts.scan_last  = (step_reg == SW'(NSTEP - 1));
    assign sts.res_free   = !res_valid_reg || !res_stall;

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    // operation applied to the row
    always_comb
    begin
        cells_exec = cells_reg;
        occ_exec   = occ_reg;
        res_exec   = '0;
        res_exec.status = ST_OK;
        case (op_reg)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    res_exec.status = ST_FULL;
                end
                else
                begin
                    for (int i = CAPACITY - 1; i > 0; i--)
                    begin
                        cells_exec[i] = cells_reg[i-1];
                    end
                    cells_exec[0] = key_reg;
                    occ_exec = occ_reg + OW'(1);
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    res_exec.status = ST_FULL;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (OW'(i) == occ_reg)
                        begin
                            cells_exec[i] = key_reg;
                        end
                    end
                    occ_exec = occ_reg + OW'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    res_exec.status = ST_EMPTY;
                end
                else
                begin
                    res_exec.removed_value = cells_reg[0];
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        cells_exec[i] = cells_reg[i+1];
                    end
                    cells_exec[CAPACITY-1] = '0;
                    occ_exec = occ_reg - OW'(1);
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    res_exec.status = ST_EMPTY;
                end
                else
                begin
                    res_exec.removed_value = cells_reg[last_idx];
                    cells_exec[last_idx] = '0;
                    occ_exec = occ_reg - OW'(1);
                end
            end
            OP_SEARCH:
            begin
                res_exec.found = hit_reg[CAPACITY-1];
            end
            OP_DELETE:
            begin
                // hit_reg is prefix-ORed: set from the first match onwards
                if (hit_reg[CAPACITY-1])
                begin
                    res_exec.found = 1'b1;
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        if (hit_reg[i])
                        begin
                            cells_exec[i] = cells_reg[i+1];
                        end
                    end
                    cells_exec[CAPACITY-1] = '0;
                    occ_exec = occ_reg - OW'(1);
                end
                else
                begin
                    res_exec.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                occ_exec = occ_reg;
            end
        endcase
        res_exec.entry_count = 5'(occ_exec);
    end

    // register updates
    always_comb
    begin
        cells_next     = cells_reg;
        occ_next       = occ_reg;
        hit_next       = hit_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (ctl.accept)
        begin
            op_next   = cmd.operation;
            key_next  = cmd.key_value;
            step_next = '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                hit_next[i] = (cells_reg[i] == cmd.key_value) && (OW'(i) < occ_reg);
            end
        end
        if (ctl.scan)
        begin
            hit_next  = hit_reg | (hit_reg << shamt);
            step_next = step_reg + SW'(1);
        end
        if (ctl.exec)
        begin
            cells_next     = cells_exec;
            occ_next       = occ_exec;
            res_next       = res_exec;
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                cells_reg[i] <= '0;
            end
            occ_reg       <= '0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cells_reg     <= cells_next;
            occ_reg       <= occ_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        op_reg  <= op_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

endmodule

>>> hw/rtl/bounded_deque_with_search_delete.sv
// Top level of the bounded deque with search and delete-by-value.
//
// Requests arrive on cmd (operation, key_value) under cmd_valid/cmd_stall;
// each request gives exactly one result on res under res_valid/res_stall.
// A request is taken at a clock edge with valid high and stall low.
// Push front/back, pop front/back and unknown codes are accepted, then
// executed: applied to the cell row and loaded into the result register.
// Search and delete-by-value pass through a match scan between the two:
// all cells are compared at accept, then the match vector is prefix-ORed
// in log2(CAPACITY) doubling steps to find the first match.
// One request is in flight at a time; cmd_stall is high from accept until
// the result is loaded. The result register frees the input side, so a
// new request is accepted while the previous result waits to be taken.
// If res_stall holds the register full, the next result waits in execute.
// Reset clears every cell, the occupancy and the result valid.
module bounded_deque_with_search_delete
#(
    parameter int CAPACITY = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  bdq_pkg::req_t  cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output bdq_pkg::res_t  res
);
    import bdq_pkg::*;

    ctrl_t      ctl;
    dp_status_t sts;

    bdq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    bdq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .sts       (sts),
        .res       (res),
        .res_valid (res_valid),
        .res_stall (res_stall)
    );

    // busy straight after a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("request accepted while previous one still in flight");

    // refused or empty operations remove nothing and match nothing
    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status == ST_EMPTY || res.status == ST_FULL))
            |-> (!res.found && res.removed_value == '0))
        else $error("empty/full result carries data");

    // found and not-found are exclusive
    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.found) |-> (res.status == ST_OK))
        else $error("match reported with non-ok status");

endmodule

>>> tb/bounded_deque_with_search_delete_tb.sv
// Self-checking testbench for the bounded deque with search and delete-by-value.
module bounded_deque_with_search_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 20;

    // Codes the block must treat as no-ops
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Operation mixes for the random phases
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the list, queues the result each request should
    // give and checks results in order as they are taken.
    // ------------------------------------------------------------------
    class deque_scoreboard;
        logic signed [31:0] cells [CAPACITY];
        int                 held;
        res_t               pending_results [$];
        int                 mismatches;

        function new();
            foreach (cells[i]) cells[i] = '0;
            held       = 0;
            mismatches = 0;
        endfunction

        // Close the gap left by a removal; later entries move to the front
        function void drop_entry(int pos);
            int i;
            for (i = pos; i + 1 < held; i++)
                cells[i] = cells[i + 1];
            cells[held - 1] = '0;
            held--;
        endfunction

        function res_t apply_operation(req_t r);
            res_t o;
            int   i;
            int   hit;
            o        = '0;
            o.status = ST_OK;
            hit      = -1;
            case (r.operation)
                OP_PUSH_FRONT:
                    if (held >= CAPACITY)
                        o.status = ST_FULL;
                    else
                    begin
                        for (i = held; i > 0; i--)
                            cells[i] = cells[i - 1];
                        cells[0] = r.key_value;
                        held++;
                    end
                OP_PUSH_BACK:
                    if (held >= CAPACITY)
                        o.status = ST_FULL;
                    else
                    begin
                        cells[held] = r.key_value;
                        held++;
                    end
                OP_POP_FRONT:
                    if (held == 0)
                        o.status = ST_EMPTY;
                    else
                    begin
                        o.removed_value = cells[0];
                        drop_entry(0);
                    end
                OP_POP_BACK:
                    if (held == 0)
                        o.status = ST_EMPTY;
                    else
                    begin
                        o.removed_value = cells[held - 1];
                        drop_entry(held - 1);
                    end
                OP_SEARCH, OP_DELETE:
                begin
                    for (i = 0; i < held && hit < 0; i++)
                        if (cells[i] == r.key_value)
                            hit = i;
                    o.found = (hit >= 0);
                    if (r.operation == OP_DELETE)
                    begin
                        // only the first match from the front goes
                        if (hit >= 0)
                            drop_entry(hit);
                        else
                            o.status = ST_NOT_FOUND;
                    end
                end
                default: ;   // spare codes leave the list alone
            endcase
            o.entry_count = held[4:0];
            return o;
        endfunction

        function void note_request(req_t r);
            pending_results.push_back(apply_operation(r));
        endfunction

        function void report_field(string field, longint want, longint got);
            if (want != got)
            begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual %p", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("removed_value", want.removed_value, got.removed_value);
                report_field("found", want.found, got.found);
                report_field("status", want.status, got.status);
                report_field("entry_count", want.entry_count, got.entry_count);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    req_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;

    deque_scoreboard sb;
    bit  quiet_phase;      // both sides run flat out while set
    int  cycles;
    int  stall_left;
    int  run_left;

    bounded_deque_with_search_delete #(.CAPACITY(CAPACITY)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 6);
        else
            return $urandom_range(10, 30);
    endfunction

    // Keys come mostly from a small pool so searches and deletes hit,
    // and duplicates turn up; the rest are full-width random words.
    function automatic logic signed [31:0] pick_key();
        if ($urandom_range(0, 99) < 40)
            return $urandom;
        case ($urandom_range(0, 7))
            0: return 32'sh0000_0000;
            1: return -32'sd1;
            2: return 32'sh7fff_ffff;
            3: return 32'sh8000_0000;
            4: return 32'sd1;
            5: return 32'sd2;
            6: return 32'sd3;
            default: return 32'sd42;
        endcase
    endfunction

    // Cumulative weights (percent) of push front, push back, pop front,
    // pop back, search and delete; the remainder goes to the spare codes.
    function automatic logic [2:0] pick_op(int mix);
        int r;
        int lim [6];
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  lim = '{35, 70, 77, 84, 91, 97};
            MIX_DRAIN: lim = '{8, 16, 43, 70, 82, 96};
            MIX_EVEN:  lim = '{20, 40, 52, 64, 80, 96};
            default:   lim = '{20, 40, 52, 64, 80, 96};
        endcase
        if (r < lim[0]) return OP_PUSH_FRONT;
        if (r < lim[1]) return OP_PUSH_BACK;
        if (r < lim[2]) return OP_POP_FRONT;
        if (r < lim[3]) return OP_POP_BACK;
        if (r < lim[4]) return OP_SEARCH;
        if (r < lim[5]) return OP_DELETE;
        return $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
    endfunction

    // Present one request at the falling edge and hold it until taken.
    // With no gap, valid stays high and only the payload moves on.
    task automatic issue_request(logic [2:0] op, logic signed [31:0] key);
        req_t r;
        int   gap;
        r.operation = op;
        r.key_value = key;
        gap = quiet_phase ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= r;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // Result side: stall in bursts of random length between runs of
    // readiness; quiet phases never stall.
    always @(negedge clk)
    begin
        if (!rst_n || quiet_phase)
            res_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            res_stall <= 1'b0;
            if (run_left > 0)
                run_left--;
            else
            begin
                run_left   = $urandom_range(0, 6);
                stall_left = pick_gap();
            end
        end
    end

    // A result is taken at a rising edge with valid high and stall low
    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res);

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        sb          = new();
        quiet_phase = 1'b0;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: everything on an empty list first, including the
        // spare codes, then extremes of the key, hits, misses and a
        // delete that removes an entry from the middle.
        issue_request(OP_POP_FRONT, $urandom);
        issue_request(OP_POP_BACK, $urandom);
        issue_request(OP_SEARCH, 32'sd0);
        issue_request(OP_DELETE, 32'sd0);
        issue_request(OP_SPARE_6, 32'sh7fff_ffff);
        issue_request(OP_SPARE_7, 32'sh8000_0000);
        issue_request(OP_PUSH_FRONT, 32'sh7fff_ffff);
        issue_request(OP_PUSH_BACK, 32'sh8000_0000);
        issue_request(OP_PUSH_BACK, 32'sd0);
        issue_request(OP_PUSH_FRONT, -32'sd1);
        issue_request(OP_SEARCH, 32'sd0);
        issue_request(OP_SEARCH, 32'sd5);
        issue_request(OP_DELETE, 32'sh8000_0000);
        issue_request(OP_DELETE, 32'sh8000_0000);
        issue_request(OP_POP_BACK, $urandom);
        issue_request(OP_POP_FRONT, $urandom);
        issue_request(OP_SPARE_6, -32'sd1);

        // Random: phases alternate between filling (so full refusals
        // turn up often), draining to empty and an even mix; every
        // fourth phase runs with no idling on either side.
        for (int phase = 0; phase < 20; phase++)
        begin
            quiet_phase = (phase % 4 == 3);
            for (int n = 0; n < 100; n++)
                issue_request(pick_op(phase % 3), pick_key());
        end

        @(negedge clk);
        cmd_valid <= 1'b0;

        // Drain, then give any stray result time to show up
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bdq_datapath.sv
hw/rtl/bounded_deque_with_search_delete.sv
tb/bounded_deque_with_search_delete_tb.sv
